// ===== src/fsc_pkg.sv =====
// ----------------------------------------------------------------------------
// fsc_pkg: shared types and constants of the frequency sketch counter
// Command codes, counter and key widths, hash constants, row seeds and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package fsc_pkg;

    // Field widths
    localparam int CntW    = 24;
    localparam int KeyW    = 64;
    localparam int CmdW    = 2;
    localparam int SeedW   = 32;
    localparam int HalfW   = 32;
    localparam int MulW    = 27;
    localparam int ProdW   = HalfW + MulW;
    localparam int RowSelW = 3;

    // Stream widths
    localparam int STdataW = KeyW;
    localparam int STuserW = CmdW;
    localparam int MTdataW = 32;
    localparam int MPadW   = MTdataW - CntW - 1;

    // Counter limits
    localparam logic [CntW-1:0] CntMax     = 24'hFF_FFFF;
    localparam logic [CntW-1:0] LimitReset = 24'd10240;

    // Hash mixing constants
    localparam logic [MulW-1:0] MixMul   = 27'h45D_9F3B;
    localparam int              MixShift = 16;
    localparam int              DigitW   = 4;
    localparam int              ModSteps = KeyW / DigitW;

    // Command codes
    localparam logic [CmdW-1:0] CmdRecord   = 2'd0;
    localparam logic [CmdW-1:0] CmdEstimate = 2'd1;
    localparam logic [CmdW-1:0] CmdClear    = 2'd2;

    // Row seed: golden-ratio step times (row + 1), modulo 2^32
    function automatic logic [SeedW-1:0] row_seed(input logic [RowSelW-1:0] row);
        logic [SeedW-1:0] seed;
        case (row)
            3'd0:    seed = 32'h9E37_79B1;
            3'd1:    seed = 32'h3C6E_F362;
            3'd2:    seed = 32'hDAA6_6D13;
            3'd3:    seed = 32'h78DD_E6C4;
            3'd4:    seed = 32'h1715_6075;
            3'd5:    seed = 32'hB54C_DA26;
            3'd6:    seed = 32'h5384_53D7;
            3'd7:    seed = 32'hF1BB_CD88;
            default: seed = 32'h9E37_79B1;
        endcase
        return seed;
    endfunction

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic hash_start;
        logic mem_rd;
        logic mem_upd;
        logic row_next;
        logic finish;
        logic sweep;
    } ctrl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_hashed;
        logic wipe;
        logic hash_done;
        logic last_row;
        logic sweep_last;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== src/frequency_sketch_counter.sv =====
// ----------------------------------------------------------------------------
// frequency_sketch_counter: count-min frequency sketch for cache admission
// DEPTH rows of WIDTH saturating 24-bit counters, recorded, estimated and
// aged under a controller that walks the rows one at a time.
//
//   Channel   Ports                        Carries
//   input     s_tvalid s_tready s_tdata    tdata: key; tuser: cmd
//             s_tuser
//   result    m_tvalid m_tready m_tdata    tdata: estimate, aged
//   config    cfg_valid cfg_ready cfg_data sample limit, always ready
//
// A record or estimate visits each row in turn: each row waits for the shared
// 32 x 27 multiplier (two rounds, two halves each) and, when WIDTH is not a
// power of two, the digit-wise reduction modulo WIDTH. A clear or an unused
// command skips the rows and goes straight to its result.
// After reset, and after any record that ages the sketch or any clear, a
// sweep over all WIDTH addresses zeroes all rows; s_tready is low meanwhile.
// The result register lets the next item in while a result waits on m_tready.
// ----------------------------------------------------------------------------
module frequency_sketch_counter #(
    parameter int WIDTH = 1024,
    parameter int DEPTH = 4
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [fsc_pkg::STdataW-1:0]   s_tdata,   // [63:0] key
    input  logic [fsc_pkg::STuserW-1:0]   s_tuser,   // [1:0] cmd
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [fsc_pkg::MTdataW-1:0]   m_tdata,   // [23:0] estimate, [24] aged
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [fsc_pkg::CntW-1:0]      cfg_data   // sample limit
);

    fsc_pkg::ctrl_cmd_t cmd;
    fsc_pkg::dp_stat_t  stat;

    // Sequencing of items and sweeps
    fsc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Hashing, counter rows and result register
    fsc_dp #(
        .WIDTH (WIDTH),
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data)
    );

    // The limit register takes a write in any cycle
    assign cfg_ready = 1'b1;

endmodule

// ===== src/fsc_hash.sv =====
// ----------------------------------------------------------------------------
// fsc_hash: iterative row index unit
// Mixes the key with a row seed through two multiply-xorshift rounds on one
// shared 32 x 27 multiplier, then reduces the result modulo WIDTH.
// ----------------------------------------------------------------------------
module fsc_hash #(
    parameter int WIDTH = 1024
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [fsc_pkg::KeyW-1:0]   key,
    input  logic [fsc_pkg::SeedW-1:0]  seed,
    output logic                       done,
    output logic [((WIDTH > 1) ? $clog2(WIDTH) : 1)-1:0] idx
);

    localparam int IdxW = (WIDTH > 1) ? $clog2(WIDTH) : 1;
    localparam int RemW = IdxW + 1;
    localparam bit Pow2 = ((WIDTH & (WIDTH - 1)) == 0);
    localparam logic [RemW-1:0] WidthR  = RemW'(WIDTH);
    localparam logic [IdxW-1:0] IdxMask = IdxW'(WIDTH - 1);
    localparam int DigCntW = $clog2(fsc_pkg::ModSteps);
    localparam logic [DigCntW-1:0] DigLast = DigCntW'(fsc_pkg::ModSteps - 1);

    localparam logic [2:0] H_IDLE   = 3'd0;
    localparam logic [2:0] H_MUL_LO = 3'd1;
    localparam logic [2:0] H_MUL_HI = 3'd2;
    localparam logic [2:0] H_MOD    = 3'd3;
    localparam logic [2:0] H_DONE   = 3'd4;

    logic [2:0]                  st_reg,     st_next;
    logic [fsc_pkg::KeyW-1:0]    h_reg,      h_next;
    logic [fsc_pkg::ProdW-1:0]   p_reg,      p_next;
    logic                        second_reg, second_next;
    logic [DigCntW-1:0]          dig_reg,    dig_next;
    logic [RemW-1:0]             rem_reg,    rem_next;
    logic [IdxW-1:0]             idx_reg,    idx_next;

    logic [fsc_pkg::KeyW-1:0]    mix_x;
    logic [fsc_pkg::HalfW-1:0]   mul_a;
    logic [fsc_pkg::ProdW-1:0]   mul_p;
    logic [fsc_pkg::KeyW-1:0]    h_prod;
    logic [fsc_pkg::KeyW-1:0]    h_fold;
    logic [RemW-1:0]             rem_step;

    // Xorshift ahead of each multiply, and the one shared multiplier
    assign mix_x = h_reg ^ (h_reg >> fsc_pkg::MixShift);
    assign mul_a = (st_reg == H_MUL_HI) ? mix_x[fsc_pkg::KeyW-1:fsc_pkg::HalfW]
                                        : mix_x[fsc_pkg::HalfW-1:0];
    assign mul_p = fsc_pkg::ProdW'(mul_a) * fsc_pkg::ProdW'(fsc_pkg::MixMul);

    // Low product plus the high product moved up by half a word, wrapping
    assign h_prod = {{(fsc_pkg::KeyW - fsc_pkg::ProdW){1'b0}}, p_reg}
                  + {mul_p[fsc_pkg::HalfW-1:0], {fsc_pkg::HalfW{1'b0}}};
    assign h_fold = h_prod ^ (h_prod >> fsc_pkg::MixShift);

    // Restoring remainder, one hex digit of the hash per cycle
    always_comb begin
        rem_step = rem_reg;
        for (int i = 0; i < fsc_pkg::DigitW; i++) begin
            rem_step = {rem_step[RemW-2:0], h_reg[fsc_pkg::KeyW-1-i]};
            if (rem_step >= WidthR) begin
                rem_step = rem_step - WidthR;
            end
        end
    end

    // Sequencer of the mixing rounds and the reduction
    always_comb begin
        st_next     = st_reg;
        h_next      = h_reg;
        p_next      = p_reg;
        second_next = second_reg;
        dig_next    = dig_reg;
        rem_next    = rem_reg;
        idx_next    = idx_reg;
        case (st_reg)
            H_IDLE: begin
                if (start) begin
                    h_next      = key ^ {{(fsc_pkg::KeyW - fsc_pkg::SeedW){1'b0}}, seed};
                    second_next = 1'b0;
                    st_next     = H_MUL_LO;
                end
            end
            H_MUL_LO: begin
                p_next  = mul_p;
                st_next = H_MUL_HI;
            end
            H_MUL_HI: begin
                if (!second_reg) begin
                    h_next      = h_prod;
                    second_next = 1'b1;
                    st_next     = H_MUL_LO;
                end else begin
                    h_next   = h_fold;
                    rem_next = '0;
                    dig_next = '0;
                    st_next  = H_MOD;
                end
            end
            H_MOD: begin
                if (Pow2) begin
                    idx_next = h_reg[IdxW-1:0] & IdxMask;
                    st_next  = H_DONE;
                end else begin
                    h_next   = h_reg << fsc_pkg::DigitW;
                    rem_next = rem_step;
                    dig_next = dig_reg + 1'b1;
                    if (dig_reg == DigLast) begin
                        idx_next = rem_step[IdxW-1:0];
                        st_next  = H_DONE;
                    end
                end
            end
            H_DONE: begin
                st_next = H_IDLE;
            end
            default: begin
                st_next = H_IDLE;
            end
        endcase
    end

    // State register with reset, working registers without
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= H_IDLE;
        end else begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge aclk) begin
        h_reg      <= h_next;
        p_reg      <= p_next;
        second_reg <= second_next;
        dig_reg    <= dig_next;
        rem_reg    <= rem_next;
        idx_reg    <= idx_next;
    end

    assign done = (st_reg == H_DONE);
    assign idx  = idx_reg;

endmodule

// ===== src/fsc_dp.sv =====
// ----------------------------------------------------------------------------
// fsc_dp: datapath of the frequency sketch counter
// Holds the item registers, the counter rows, the access count, the sample
// limit, the clearing sweep and the output register.
// ----------------------------------------------------------------------------
module fsc_dp #(
    parameter int WIDTH = 1024,
    parameter int DEPTH = 4
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  fsc_pkg::ctrl_cmd_t            cmd,
    output fsc_pkg::dp_stat_t             stat,
    input  logic [fsc_pkg::STdataW-1:0]   s_tdata,
    input  logic [fsc_pkg::STuserW-1:0]   s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [fsc_pkg::MTdataW-1:0]   m_tdata,
    input  logic                          cfg_valid,
    input  logic [fsc_pkg::CntW-1:0]      cfg_data
);

    localparam int IdxW = (WIDTH > 1) ? $clog2(WIDTH) : 1;
    localparam int RowW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [fsc_pkg::CmdW-1:0]    cmd_reg,    cmd_next;
    logic [fsc_pkg::KeyW-1:0]    key_reg,    key_next;
    logic [RowW-1:0]             row_reg,    row_next;
    logic [fsc_pkg::CntW-1:0]    min_reg,    min_next;
    logic [fsc_pkg::CntW-1:0]    cnt_reg,    cnt_next;
    logic [fsc_pkg::CntW-1:0]    limit_reg,  limit_next;
    logic [IdxW-1:0]             sweep_reg,  sweep_next;
    logic                        mvalid_reg, mvalid_next;
    logic [fsc_pkg::MTdataW-1:0] mdata_reg,  mdata_next;

    logic                        is_record;
    logic                        is_estimate;
    logic                        is_clear;
    logic                        hash_done;
    logic [IdxW-1:0]             hash_idx;
    logic [fsc_pkg::CntW-1:0]    rd_cur;
    logic [fsc_pkg::CntW-1:0]    inc_val;
    logic [fsc_pkg::CntW-1:0]    cnt_inc;
    logic                        aged_now;
    logic                        sweep_last;
    logic [IdxW-1:0]             wr_addr;
    logic [fsc_pkg::CntW-1:0]    wr_data;
    logic [fsc_pkg::CntW-1:0]    est_val;
    logic                        aged_bit;
    wire  [DEPTH-1:0][fsc_pkg::CntW-1:0] rd_all;

    // Command decode of the item in hand
    assign is_record   = (cmd_reg == fsc_pkg::CmdRecord);
    assign is_estimate = (cmd_reg == fsc_pkg::CmdEstimate);
    assign is_clear    = (cmd_reg == fsc_pkg::CmdClear);

    // Row index of the current row
    fsc_hash #(
        .WIDTH (WIDTH)
    ) u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.hash_start),
        .key     (key_reg),
        .seed    (fsc_pkg::row_seed(fsc_pkg::RowSelW'(row_reg))),
        .done    (hash_done),
        .idx     (hash_idx)
    );

    // Saturating counter increment and access count
    assign rd_cur   = rd_all[row_reg];
    assign inc_val  = (rd_cur == fsc_pkg::CntMax) ? rd_cur : rd_cur + 1'b1;
    assign cnt_inc  = (cnt_reg == fsc_pkg::CntMax) ? cnt_reg : cnt_reg + 1'b1;
    assign aged_now = (cnt_inc >= limit_reg);

    // The sweep takes the single write port of every row
    assign sweep_last = (sweep_reg == IdxW'(WIDTH - 1));
    assign wr_addr    = cmd.sweep ? sweep_reg : hash_idx;
    assign wr_data    = cmd.sweep ? '0 : inc_val;

    // One counter memory per row; all rows are cleared together by the sweep
    for (genvar r = 0; r < DEPTH; r++) begin : g_row
        logic [fsc_pkg::CntW-1:0] mem [WIDTH];
        logic [fsc_pkg::CntW-1:0] rd_data_reg;
        logic                     wr_en;

        assign wr_en = cmd.sweep
                    || (cmd.mem_upd && is_record && (row_reg == RowW'(r)));

        always_ff @(posedge aclk) begin
            if (wr_en) begin
                mem[wr_addr] <= wr_data;
            end
            if (cmd.mem_rd) begin
                rd_data_reg <= mem[hash_idx];
            end
        end

        assign rd_all[r] = rd_data_reg;
    end

    // Result fields
    assign est_val  = is_estimate ? min_reg : '0;
    assign aged_bit = is_record && aged_now;

    // Next values of the datapath registers
    always_comb begin
        cmd_next    = cmd_reg;
        key_next    = key_reg;
        row_next    = row_reg;
        min_next    = min_reg;
        cnt_next    = cnt_reg;
        limit_next  = limit_reg;
        sweep_next  = sweep_reg;
        mvalid_next = mvalid_reg;
        mdata_next  = mdata_reg;

        if (cmd.accept) begin
            cmd_next = s_tuser;
            key_next = s_tdata;
            row_next = '0;
            min_next = fsc_pkg::CntMax;
        end
        if (cmd.mem_upd && is_estimate && (rd_cur < min_reg)) begin
            min_next = rd_cur;
        end
        if (cmd.row_next) begin
            row_next = row_reg + 1'b1;
        end
        if (cmd.sweep) begin
            sweep_next = sweep_last ? '0 : sweep_reg + 1'b1;
        end

        // Output register: a finished item loads it, a transfer empties it
        if (cmd.finish) begin
            mvalid_next = 1'b1;
            mdata_next  = {{fsc_pkg::MPadW{1'b0}}, aged_bit, est_val};
            if (is_record) begin
                cnt_next = aged_now ? '0 : cnt_inc;
            end else if (is_clear) begin
                cnt_next = '0;
            end
        end else if (m_tready) begin
            mvalid_next = 1'b0;
        end

        if (cfg_valid) begin
            limit_next = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_reg    <= fsc_pkg::CmdRecord;
            row_reg    <= '0;
            cnt_reg    <= '0;
            limit_reg  <= fsc_pkg::LimitReset;
            sweep_reg  <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            cmd_reg    <= cmd_next;
            row_reg    <= row_next;
            cnt_reg    <= cnt_next;
            limit_reg  <= limit_next;
            sweep_reg  <= sweep_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg   <= key_next;
        min_reg   <= min_next;
        mdata_reg <= mdata_next;
    end

    // Status back to the controller
    assign stat.is_hashed  = is_record || is_estimate;
    assign stat.wipe       = (is_record && aged_now) || is_clear;
    assign stat.hash_done  = hash_done;
    assign stat.last_row   = (row_reg == RowW'(DEPTH - 1));
    assign stat.sweep_last = sweep_last;
    assign stat.out_free   = !mvalid_reg || m_tready;

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

endmodule

// ===== src/fsc_ctrl.sv =====
// ----------------------------------------------------------------------------
// fsc_ctrl: controller of the frequency sketch counter
// Steps each record or estimate through the rows (hash, read, update), issues
// the result and runs the clearing sweep after reset and after every wipe.
// ----------------------------------------------------------------------------
module fsc_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  fsc_pkg::dp_stat_t  stat,
    output fsc_pkg::ctrl_cmd_t cmd
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_HSTART = 3'd2;
    localparam logic [2:0] S_HWAIT  = 3'd3;
    localparam logic [2:0] S_UPDATE = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    logic [2:0] state_reg, state_next;

    // Next state and command decode
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR: begin
                cmd.sweep = 1'b1;
                if (stat.sweep_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = S_HSTART;
                end
            end
            S_HSTART: begin
                if (stat.is_hashed) begin
                    cmd.hash_start = 1'b1;
                    state_next     = S_HWAIT;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_HWAIT: begin
                if (stat.hash_done) begin
                    cmd.mem_rd = 1'b1;
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE: begin
                cmd.mem_upd = 1'b1;
                if (stat.last_row) begin
                    state_next = S_FINISH;
                end else begin
                    cmd.row_next = 1'b1;
                    state_next   = S_HSTART;
                end
            end
            S_FINISH: begin
                if (stat.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = stat.wipe ? S_CLEAR : S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // Reset starts with a sweep of the counter rows
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

endmodule

// ===== src/fsc_checker.sv =====
// ----------------------------------------------------------------------------
// fsc_checker: port-level checks of the frequency sketch counter
// Watches the stream ports of the top level and is bound to it below.
// ----------------------------------------------------------------------------
module fsc_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [fsc_pkg::MTdataW-1:0] m_tdata
);

    // Only one item is in work: ready drops after every input transfer
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted again straight after a transfer");

    // A stalled result holds its value
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // An aged record never reports an estimate
    a_aged_est: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[fsc_pkg::CntW]
                       && (m_tdata[fsc_pkg::CntW-1:0] != '0)))
        else $error("aged result carries a nonzero estimate");

    // An aged result starts the sweep, so input is held off
    a_aged_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) && m_tdata[fsc_pkg::CntW] |-> !s_tready)
        else $error("input ready while the sketch is being wiped");

endmodule

bind frequency_sketch_counter fsc_checker u_fsc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== sim/frequency_sketch_counter_tb.sv =====
// ----------------------------------------------------------------------------
// frequency_sketch_counter_tb: self-checking bench for the frequency sketch
// Sends record, estimate, clear and unused commands over the input stream,
// rewrites the sample limit between phases, and checks every result transfer
// against a count-min sketch kept in the bench with its own counters and ageing.
// ----------------------------------------------------------------------------
module frequency_sketch_counter_tb;

    localparam int CntW    = fsc_pkg::CntW;
    localparam int KeyW    = fsc_pkg::KeyW;
    localparam int CmdW    = fsc_pkg::CmdW;
    localparam int SeedW   = fsc_pkg::SeedW;
    localparam int STdataW = fsc_pkg::STdataW;
    localparam int STuserW = fsc_pkg::STuserW;
    localparam int MTdataW = fsc_pkg::MTdataW;

    localparam int SketchWidth = 1024;
    localparam int SketchRows  = 4;
    localparam int PoolSize    = 16;
    localparam int QuietCycles = SketchWidth + 64;
    localparam int TailCycles  = 200;
    localparam int CycleLimit  = 3_000_000;
    localparam int PlanLen     = 27;

    localparam logic [CmdW-1:0]  CmdUnused = 2'd3;
    localparam logic [SeedW-1:0] SeedStep  = 32'd2654435761;
    localparam logic [KeyW-1:0]  MixWide   = KeyW'(fsc_pkg::MixMul);

    // Block ports
    logic               aclk;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [STdataW-1:0] s_tdata;
    logic [STuserW-1:0] s_tuser;
    logic               m_tvalid;
    logic               m_tready;
    logic [MTdataW-1:0] m_tdata;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [CntW-1:0]    cfg_data;

    // One result as the block reports it
    typedef struct packed {
        logic [CntW-1:0] estimate;
        logic            aged;
    } sketch_answer_t;

    // One row of the directed plan: either a limit write or a command
    typedef struct packed {
        logic            is_cfg;
        logic [CntW-1:0] limit;
        logic [CmdW-1:0] cmd;
        logic [KeyW-1:0] key;
        logic            typed;
        logic [CntW-1:0] estimate;
        logic            aged;
    } plan_step_t;

    // Bench copy of the sketch
    logic [CntW-1:0] tally [SketchRows][SketchWidth];
    logic [CntW-1:0] accesses;
    logic [CntW-1:0] limit_now;
    sketch_answer_t  answers_due [$];
    logic [KeyW-1:0] key_pool [PoolSize];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    int cycles         = 0;
    int mismatches     = 0;
    int n_record       = 0;
    int n_estimate     = 0;
    int n_clear        = 0;
    int n_unused       = 0;
    int n_aged         = 0;
    int n_limits       = 0;
    logic [CntW-1:0] est_peak = '0;

    // Directed plan: extremes of the key, every command, the limit at its
    // extremes and at zero, and a limit lowered below the running count.
    plan_step_t plan [PlanLen] = '{
        '{1'b0, 24'd0, fsc_pkg::CmdEstimate, 64'h0000_0000_0000_0000, 1'b1, 24'd0, 1'b0},
        '{1'b0, 24'd0, fsc_pkg::CmdEstimate, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 24'd0, 1'b0},
        '{1'b0, 24'd0, fsc_pkg::CmdRecord,   64'h0000_0000_0000_0000, 1'b1, 24'd0, 1'b0},
        '{1'b0, 24'd0, fsc_pkg::CmdRecord,   64'h0000_0000_0000_0000, 1'b0, 24'd0, 1'b0},
        '{1'b0, 24'd0, fsc_pkg::CmdRecord,   64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 24'd0, 1'b0},
        '{1'b0, 24'd0, fsc_pkg::CmdEstimate, 64'h0000_0000_0000_0000, 1'b0, 24'd0, 1'b0},
        '{1'b0, 24'd0, fsc_pkg::CmdEstimate, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 24'd0, 1'b0},
        // The unused command leaves the sketch alone and answers zero
        '{1'b0, 24'd0, CmdUnused,            64'hA5A5_A5A5_A5A5_A5A5, 1'b1, 24'd0, 1'b0},
        '{1'b0, 24'd0, fsc_pkg::CmdEstimate, 64'h0000_0000_0000_0000, 1'b0, 24'd0, 1'b0},
        // Clear, then everything reads zero again
        '{1'b0, 24'd0, fsc_pkg::CmdClear,    64'h0000_0000_0000_0000, 1'b1, 24'd0, 1'b0},
        '{1'b0, 24'd0, fsc_pkg::CmdEstimate, 64'h0000_0000_0000_0000, 1'b1, 24'd0, 1'b0},
        '{1'b0, 24'd0, fsc_pkg::CmdRecord,   64'h5A5A_5A5A_5A5A_5A5A, 1'b0, 24'd0, 1'b0},
        '{1'b0, 24'd0, fsc_pkg::CmdEstimate, 64'h5A5A_5A5A_5A5A_5A5A, 1'b0, 24'd0, 1'b0},
        // A limit of one: every record ages the sketch
        '{1'b1, 24'd1, fsc_pkg::CmdRecord,   64'h0000_0000_0000_0000, 1'b0, 24'd0, 1'b0},
        '{1'b0, 24'd0, fsc_pkg::CmdRecord,   64'h0123_4567_89AB_CDEF, 1'b1, 24'd0, 1'b1},
        '{1'b0, 24'd0, fsc_pkg::CmdEstimate, 64'h0123_4567_89AB_CDEF, 1'b1, 24'd0, 1'b0},
        // A zero limit behaves the same way
        '{1'b1, 24'd0, fsc_pkg::CmdRecord,   64'h0000_0000_0000_0000, 1'b0, 24'd0, 1'b0},
        '{1'b0, 24'd0, fsc_pkg::CmdRecord,   64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 24'd0, 1'b1},
        // Largest limit, build a count, then drop the limit beneath it
        '{1'b1, 24'hFF_FFFF, fsc_pkg::CmdRecord, 64'h0000_0000_0000_0000, 1'b0, 24'd0, 1'b0},
        '{1'b0, 24'd0, fsc_pkg::CmdRecord,   64'h5555_5555_5555_5555, 1'b0, 24'd0, 1'b0},
        '{1'b0, 24'd0, fsc_pkg::CmdRecord,   64'h5555_5555_5555_5555, 1'b0, 24'd0, 1'b0},
        '{1'b0, 24'd0, fsc_pkg::CmdRecord,   64'h5555_5555_5555_5555, 1'b0, 24'd0, 1'b0},
        '{1'b0, 24'd0, fsc_pkg::CmdEstimate, 64'h5555_5555_5555_5555, 1'b0, 24'd0, 1'b0},
        '{1'b1, 24'd2, fsc_pkg::CmdRecord,   64'h0000_0000_0000_0000, 1'b0, 24'd0, 1'b0},
        '{1'b0, 24'd0, fsc_pkg::CmdRecord,   64'hFEDC_BA98_7654_3210, 1'b1, 24'd0, 1'b1},
        '{1'b0, 24'd0, fsc_pkg::CmdEstimate, 64'h5555_5555_5555_5555, 1'b1, 24'd0, 1'b0},
        '{1'b1, fsc_pkg::LimitReset, fsc_pkg::CmdRecord,
          64'h0000_0000_0000_0000, 1'b0, 24'd0, 1'b0}
    };

    frequency_sketch_counter u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // [63:0] key
        .s_tuser   (s_tuser),    // [1:0] cmd
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // [23:0] estimate, [24] aged
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Column of a key in one row: seeded xor, two multiply-xorshift rounds.
    function automatic int sketch_slot(input logic [KeyW-1:0] key, input int row);
        logic [SeedW-1:0] seed;
        logic [KeyW-1:0]  h;
        seed = SeedStep * SeedW'(row + 1);
        h    = key ^ KeyW'(seed);
        h    = ((h >> fsc_pkg::MixShift) ^ h) * MixWide;
        h    = ((h >> fsc_pkg::MixShift) ^ h) * MixWide;
        h    = (h >> fsc_pkg::MixShift) ^ h;
        return int'(h % KeyW'(SketchWidth));
    endfunction

    function automatic void sketch_wipe();
        foreach (tally[r, i]) tally[r][i] = '0;
        accesses = '0;
    endfunction

    // Apply one command to the bench sketch and return what the block owes.
    function automatic sketch_answer_t sketch_predict(input logic [CmdW-1:0] cmd,
                                                      input logic [KeyW-1:0] key);
        sketch_answer_t ans;
        int             slot;
        ans = '0;
        case (cmd)
            fsc_pkg::CmdRecord: begin
                n_record++;
                for (int r = 0; r < SketchRows; r++) begin
                    slot = sketch_slot(key, r);
                    if (tally[r][slot] < fsc_pkg::CntMax) tally[r][slot]++;
                end
                if (accesses < fsc_pkg::CntMax) accesses++;
                if (accesses >= limit_now) begin
                    sketch_wipe();
                    ans.aged = 1'b1;
                    n_aged++;
                end
            end
            fsc_pkg::CmdEstimate: begin
                n_estimate++;
                ans.estimate = fsc_pkg::CntMax;
                for (int r = 0; r < SketchRows; r++) begin
                    slot = sketch_slot(key, r);
                    if (tally[r][slot] < ans.estimate) ans.estimate = tally[r][slot];
                end
                if (ans.estimate > est_peak) est_peak = ans.estimate;
            end
            fsc_pkg::CmdClear: begin
                n_clear++;
                sketch_wipe();
            end
            default: begin
                n_unused++;
            end
        endcase
        return ans;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("cycle %0d: mismatch: %s", cycles, what);
    endtask

    // Offer one command; the expectation is queued once the transfer happens.
    task automatic send_item(input logic [CmdW-1:0] cmd, input logic [KeyW-1:0] key,
                             input logic typed, input sketch_answer_t typed_ans);
        sketch_answer_t ans;
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= key;
        s_tuser  <= cmd;
        do @(posedge aclk); while (!s_tready);
        ans = sketch_predict(cmd, key);
        if (typed) ans = typed_ans;
        answers_due = {answers_due, ans};
    endtask

    // Stop offering and wait for every outstanding result.
    task automatic drain_answers();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (answers_due.size() != 0) @(posedge aclk);
    endtask

    // Limit writes happen only with the block idle, after any sweep has ended.
    task automatic write_limit(input logic [CntW-1:0] value);
        drain_answers();
        repeat (QuietCycles) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        limit_now = value;
        n_limits++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Random phase: mostly records and estimates over a small key pool so
    // that counters build up, with the odd stray key, unused command or clear.
    task automatic run_phase(input logic [CntW-1:0] limit, input int send_pct,
                             input int recv_pct, input int n_items, input int hold,
                             input bit pause_midway);
        int              done;
        int              pick;
        logic [CmdW-1:0] cmd;
        logic [KeyW-1:0] key;
        write_limit(limit);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        hold_left      = hold;
        done           = 0;
        while (done < n_items) begin
            pick = $urandom_range(99);
            if ($urandom_range(7) == 0) key = {$urandom, $urandom};
            else key = key_pool[$urandom_range(PoolSize - 1)];
            if (pick < 56) cmd = fsc_pkg::CmdRecord;
            else if (pick < 90) cmd = fsc_pkg::CmdEstimate;
            else if (pick < 97) cmd = CmdUnused;
            else cmd = fsc_pkg::CmdClear;
            send_item(cmd, key, 1'b0, '0);
            done++;
            if (pause_midway && done == n_items / 2) drain_answers();
        end
    endtask

    // Clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Run limit
    always @(posedge aclk) begin
        cycles = cycles + 1;
        if (cycles >= CycleLimit) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result side: random stalls, plus a long hold-off counted down here.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Compare each result transfer with the oldest expectation.
    always @(posedge aclk) begin : result_check
        sketch_answer_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (answers_due.size() == 0) begin
                report_mismatch($sformatf("result %h with nothing outstanding", m_tdata));
            end else begin
                want = answers_due.pop_front();
                if (m_tdata[CntW-1:0] !== want.estimate)
                    report_mismatch($sformatf("estimate %0d, wanted %0d",
                                              m_tdata[CntW-1:0], want.estimate));
                if (m_tdata[CntW] !== want.aged)
                    report_mismatch($sformatf("aged %b, wanted %b",
                                              m_tdata[CntW], want.aged));
            end
        end
    end

    // Stimulus
    initial begin : stimulus
        plan_step_t step;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        limit_now = fsc_pkg::LimitReset;
        sketch_wipe();
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < PoolSize; i++) key_pool[i] = {$urandom, $urandom};

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed plan, no idling on either side
        for (int i = 0; i < PlanLen; i++) begin
            step = plan[i];
            if (step.is_cfg) write_limit(step.limit);
            else send_item(step.cmd, step.key, step.typed,
                           sketch_answer_t'{step.estimate, step.aged});
        end

        // Random phases over several limits and idling patterns
        run_phase(fsc_pkg::LimitReset, 0, 0, 120, 0, 1'b0);
        run_phase(24'd7, 78, 0, 90, 0, 1'b0);
        run_phase(24'hFF_FFFF, 0, 78, 90, 400, 1'b0);
        run_phase(24'd1, 11, 11, 60, 0, 1'b1);
        run_phase(24'd33, 11, 11, 110, 300, 1'b1);
        run_phase(CntW'($urandom_range(64, 2)), 0, 0, 60, 0, 1'b0);

        drain_answers();
        repeat (TailCycles) @(posedge aclk);

        $display("Covered %0d records, %0d estimates, %0d clears, %0d unused commands,",
                 n_record, n_estimate, n_clear, n_unused);
        $display("%0d limits; the sketch aged %0d times; the largest estimate was %0d.",
                 n_limits, n_aged, est_peak);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
